// ===== design/rgb_running_box_filter_core_assert.svh =====
// Assertion macros for the RGB running box filter core.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef RGB_RUNNING_BOX_FILTER_CORE_ASSERT_SVH
`define RGB_RUNNING_BOX_FILTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define RGBBOX_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RGBBOX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RGBBOX_ASSERT_IMPLY(label, ante, cons, msg)
`define RGBBOX_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== design/rgbbox_pkg.sv =====
`timescale 1ns / 1ps

package rgbbox_pkg;

    // Pixel layout shared by the stream ports and the window memory:
    // red in the lowest byte, then green, then blue.
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int PIX_W    = CHAN_W * NUM_CHAN;

    // Width of the window length register.
    localparam int LEN_REG_W = 7;

    // Number of quotient bits the divider produces, one per step.
    localparam int DIV_STEPS   = CHAN_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0]  pixel_t;

endpackage

// ===== design/rgbbox_ram.sv =====
`timescale 1ns / 1ps

module rgbbox_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/rgb_running_box_filter_core.sv =====
`timescale 1ns / 1ps
// Channel       Direction  Handshake                     Payload
// pixel in      slave      s_tvalid / s_tready           s_tdata (R,G,B), s_tuser (line start)
// pixel out     master     m_tvalid / m_tready           m_tdata (R,G,B)
// length cfg    write      window_length_wr_en           window_length_wr_data
//
// Each pixel passes from acceptance to the next acceptance through one memory read, one
// read-modify-write, eight divider steps and one hand-off to the output register, which
// waits while that register holds an untaken pixel. The divider is an 8-step restoring one.
// Reset is asynchronous and active low; the window memory is never cleared.
// A finished pixel waits in the output register while the next one is accepted;
// only a second finished pixel stalls until the first has been taken.

`include "rgb_running_box_filter_core_assert.svh"

module rgb_running_box_filter_core #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // Window length register.
    input  logic                                 window_length_wr_en,
    input  logic [rgbbox_pkg::LEN_REG_W-1:0]     window_length_wr_data,

    // Input pixel stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rgbbox_pkg::PIX_W-1:0]         s_tdata,  // red_in, green_in, blue_in
    input  logic                                 s_tuser,  // line_start

    // Output pixel stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rgbbox_pkg::PIX_W-1:0]         m_tdata   // red_out, green_out, blue_out
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = $clog2(MAX_WINDOW * 255 + 1);

    localparam int NC = rgbbox_pkg::NUM_CHAN;
    localparam int CW = rgbbox_pkg::CHAN_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                         state_reg;
    logic [2:0]                         state_next;
    logic [rgbbox_pkg::LEN_REG_W-1:0]   window_length_reg;
    logic [LEN_W-1:0]                   active_len_reg;
    logic [LEN_W-1:0]                   active_len_next;
    logic [ADDR_W-1:0]                  write_slot_reg;
    logic [ADDR_W-1:0]                  write_slot_next;
    logic [LEN_W-1:0]                   written_cnt_reg;
    logic [LEN_W-1:0]                   written_cnt_next;
    logic [ADDR_W-1:0]                  slot_reg;
    logic [ADDR_W-1:0]                  slot_next;
    rgbbox_pkg::pixel_t                 edge_reg;
    rgbbox_pkg::pixel_t                 edge_next;
    rgbbox_pkg::pixel_t                 pix_reg;
    rgbbox_pkg::pixel_t                 pix_next;
    logic [SUM_W-1:0]                   sum_reg [NC];
    logic [SUM_W-1:0]                   sum_next [NC];
    logic [LEN_W-1:0]                   rem_reg [NC];
    logic [LEN_W-1:0]                   rem_next [NC];
    rgbbox_pkg::chan_t                  quo_reg [NC];
    rgbbox_pkg::chan_t                  quo_next [NC];
    logic [rgbbox_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic [rgbbox_pkg::DIV_CNT_W-1:0]   div_cnt_next;
    logic                               m_tvalid_reg;
    logic                               m_tvalid_next;
    rgbbox_pkg::pixel_t                 m_tdata_reg;
    rgbbox_pkg::pixel_t                 m_tdata_next;

    logic                               in_fire;
    logic [LEN_W-1:0]                   cfg_len;
    logic [LEN_W-1:0]                   slot_inc;
    rgbbox_pkg::pixel_t                 old_pix;
    rgbbox_pkg::pixel_t                 ram_rd_data;
    logic                               ram_wr_en;
    logic                               ram_rd_en;
    logic                               out_free;

    // Window memory: one pixel per slot, read in the cycle before the update.
    rgbbox_ram #(
        .WIDTH (rgbbox_pkg::PIX_W),
        .DEPTH (MAX_WINDOW)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (pix_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_next),
        .rd_data (ram_rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign ram_rd_en = (state_reg == ST_READ);
    assign ram_wr_en = (state_reg == ST_UPD);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Clamp the programmed length to 1..MAX_WINDOW.
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            cfg_len = LEN_W'(1);
        end
        else if (32'(window_length_reg) > 32'(MAX_WINDOW))
        begin
            cfg_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_len = LEN_W'(window_length_reg);
        end
    end

    // Oldest pixel: stored entry if written in this line, else the line's first pixel.
    assign old_pix  = (LEN_W'(slot_reg) < written_cnt_reg) ? ram_rd_data : edge_reg;
    assign slot_inc = LEN_W'(slot_reg) + LEN_W'(1);

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        logic [LEN_W:0] trial;

        state_next       = state_reg;
        active_len_next  = active_len_reg;
        write_slot_next  = write_slot_reg;
        written_cnt_next = written_cnt_reg;
        slot_next        = slot_reg;
        edge_next        = edge_reg;
        pix_next         = pix_reg;
        div_cnt_next     = div_cnt_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        trial            = '0;
        for (int c = 0; c < NC; c++)
        begin
            sum_next[c] = sum_reg[c];
            rem_next[c] = rem_reg[c];
            quo_next[c] = quo_reg[c];
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Accept a pixel; a line start restarts the window on that pixel.
                if (in_fire)
                begin
                    pix_next   = s_tdata;
                    state_next = ST_READ;
                    if (s_tuser)
                    begin
                        active_len_next  = cfg_len;
                        edge_next        = s_tdata;
                        write_slot_next  = '0;
                        written_cnt_next = '0;
                        for (int c = 0; c < NC; c++)
                        begin
                            sum_next[c] = SUM_W'(cfg_len) * SUM_W'(s_tdata[c*CW +: CW]);
                        end
                    end
                end
            end

            ST_READ:
            begin
                // Pick the slot to replace and read it.
                if (LEN_W'(write_slot_reg) >= active_len_reg)
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = write_slot_reg;
                end
                state_next = ST_UPD;
            end

            ST_UPD:
            begin
                // Swap the oldest pixel for the new one and start the division.
                for (int c = 0; c < NC; c++)
                begin
                    sum_next[c] = sum_reg[c] - SUM_W'(old_pix[c*CW +: CW])
                                  + SUM_W'(pix_reg[c*CW +: CW]);
                    rem_next[c] = LEN_W'(sum_next[c] >> CW);
                    quo_next[c] = sum_next[c][CW-1:0];
                end
                if (slot_inc >= active_len_reg)
                begin
                    write_slot_next = '0;
                end
                else
                begin
                    write_slot_next = ADDR_W'(slot_inc);
                end
                if (written_cnt_reg < active_len_reg)
                begin
                    written_cnt_next = written_cnt_reg + LEN_W'(1);
                end
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end

            ST_DIV:
            begin
                // One restoring division step per cycle on each channel.
                for (int c = 0; c < NC; c++)
                begin
                    trial = {rem_reg[c], quo_reg[c][CW-1]};
                    if (trial >= {1'b0, active_len_reg})
                    begin
                        rem_next[c] = LEN_W'(trial - {1'b0, active_len_reg});
                        quo_next[c] = {quo_reg[c][CW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[c] = LEN_W'(trial);
                        quo_next[c] = {quo_reg[c][CW-2:0], 1'b0};
                    end
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == rgbbox_pkg::DIV_CNT_W'(rgbbox_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hand the quotients to the output register once it is free.
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    for (int c = 0; c < NC; c++)
                    begin
                        m_tdata_next[c*CW +: CW] = quo_reg[c];
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_length_reg <= rgbbox_pkg::LEN_REG_W'(1);
            active_len_reg    <= LEN_W'(1);
            write_slot_reg    <= '0;
            written_cnt_reg   <= '0;
            edge_reg          <= '0;
            div_cnt_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
            for (int c = 0; c < NC; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            active_len_reg  <= active_len_next;
            write_slot_reg  <= write_slot_next;
            written_cnt_reg <= written_cnt_next;
            edge_reg        <= edge_next;
            div_cnt_reg     <= div_cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
            for (int c = 0; c < NC; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
            if (window_length_wr_en)
            begin
                window_length_reg <= window_length_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        pix_reg     <= pix_next;
        m_tdata_reg <= m_tdata_next;
        for (int c = 0; c < NC; c++)
        begin
            rem_reg[c] <= rem_next[c];
            quo_reg[c] <= quo_next[c];
        end
    end

    // Checks on the window bookkeeping and the divider.
    `RGBBOX_ASSERT_IMPLY(a_count_within_len, 1'b1,
        written_cnt_reg <= active_len_reg, "fill count exceeds window length")
    `RGBBOX_ASSERT_IMPLY(a_slot_within_len, state_reg == ST_IDLE,
        LEN_W'(write_slot_reg) < active_len_reg, "write slot outside window")
    `RGBBOX_ASSERT_IMPLY(a_rem_below_len, state_reg == ST_DONE,
        (rem_reg[0] < active_len_reg) && (rem_reg[1] < active_len_reg)
        && (rem_reg[2] < active_len_reg), "divider remainder not reduced")
    `RGBBOX_ASSERT_NEXT(a_accept_reads, in_fire,
        (state_reg == ST_READ) && !s_tready, "accepted pixel did not start a window read")

endmodule

// ===== bench/tb_rgb_running_box_filter_core.sv =====
`timescale 1ns / 1ps

module tb_rgb_running_box_filter_core;

    localparam int MAX_WINDOW = 64;
    localparam int NUM_CHAN   = rgbbox_pkg::NUM_CHAN;
    localparam int CHAN_W     = rgbbox_pkg::CHAN_W;
    localparam int LEN_REG_W  = rgbbox_pkg::LEN_REG_W;
    localparam int PIX_W      = rgbbox_pkg::PIX_W;

    // Flags used in the directed table.
    localparam bit LEN_WRITE = 1'b1;
    localparam bit LEN_KEEP  = 1'b0;
    localparam bit GOLDEN    = 1'b1;
    localparam bit PREDICTED = 1'b0;

    // One pixel as three lanes; lane 0 is red in the lowest byte, as on the stream ports.
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] lanes_t;

    // One row of the directed table: an optional length write, then one pixel.
    typedef struct packed {
        bit                   wr;
        logic [LEN_REG_W-1:0] len;
        lanes_t               px;
        bit                   ls;
        bit                   typed;
        lanes_t               golden;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 window_length_wr_en;
    logic [LEN_REG_W-1:0] window_length_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata;   // red_in, green_in, blue_in
    logic                 s_tuser;   // line_start
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PIX_W-1:0]     m_tdata;   // red_out, green_out, blue_out

    // Filter state mirrored by the predictor.
    logic [LEN_REG_W-1:0] cfg_len;
    logic [LEN_REG_W-1:0] active_len;
    lanes_t               window_mem [MAX_WINDOW];
    logic [5:0]           wr_slot;
    logic [LEN_REG_W-1:0] fill_cnt;
    lanes_t               line_edge;
    logic [13:0]          lane_sum [NUM_CHAN];

    lanes_t  pending_pixels [$];
    step_t   directed_steps [$];
    int      mismatch_count;
    bit      calm;
    bit      long_hold_req;
    string   lane_name [NUM_CHAN] = '{"red_out", "green_out", "blue_out"};

    rgb_running_box_filter_core #(
        .MAX_WINDOW(MAX_WINDOW)
    ) DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .window_length_wr_en   (window_length_wr_en),
        .window_length_wr_data (window_length_wr_data),
        .s_tvalid              (s_tvalid),
        .s_tready              (s_tready),
        .s_tdata               (s_tdata),
        .s_tuser               (s_tuser),
        .m_tvalid              (m_tvalid),
        .m_tready              (m_tready),
        .m_tdata               (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    // A written length of zero acts as one, anything above the store size as the store size.
    function automatic int unsigned effective_length(logic [LEN_REG_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_WINDOW)
            return MAX_WINDOW;
        return len;
    endfunction

    // Advances the running sums by one pixel and returns the averaged pixel.
    function automatic lanes_t box_filter_predict(lanes_t px, bit ls);
        lanes_t      avg_px;
        lanes_t      oldest;
        int unsigned n;
        int unsigned slot;
        int unsigned quot;
        if (ls)
        begin
            active_len = LEN_REG_W'(effective_length(cfg_len));
            line_edge  = px;
            for (int c = 0; c < NUM_CHAN; c++)
                lane_sum[c] = 14'(active_len) * 14'(px[c]);
            wr_slot  = 0;
            fill_cnt = 0;
        end
        n    = effective_length(active_len);
        slot = wr_slot;
        if (slot >= n)
            slot = 0;
        // Slots not yet written in this line stand for the line's first pixel.
        oldest = (slot < fill_cnt) ? window_mem[slot] : line_edge;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            lane_sum[c] = lane_sum[c] - oldest[c] + px[c];
            quot        = lane_sum[c] / n;
            avg_px[c]   = (quot > 255) ? 8'd255 : quot[7:0];
        end
        window_mem[slot] = px;
        wr_slot          = 6'((slot + 1 >= n) ? 0 : slot + 1);
        if (fill_cnt < n)
            fill_cnt = fill_cnt + 1'b1;
        return avg_px;
    endfunction

    // Compares one output transaction with the oldest expected pixel.
    function automatic void check_filtered(lanes_t got);
        lanes_t want;
        if (pending_pixels.size() == 0)
        begin
            $error("unexpected output transaction: %h", got);
            mismatch_count++;
            return;
        end
        want = pending_pixels.pop_front();
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            if (got[c] !== want[c])
            begin
                $error("%s mismatch: expected %0d, actual %0d",
                       lane_name[c], want[c], got[c]);
                mismatch_count++;
            end
        end
    endfunction

    task automatic add_step(bit wr, int len, int r, int g, int b, bit ls,
                            bit typed, int er, int eg, int eb);
        step_t s;
        s.wr     = wr;
        s.len    = LEN_REG_W'(len);
        s.px     = {b[7:0], g[7:0], r[7:0]};
        s.ls     = ls;
        s.typed  = typed;
        s.golden = {eb[7:0], eg[7:0], er[7:0]};
        directed_steps.push_back(s);
    endtask

    // Offers one pixel and waits for the input transaction; tvalid stays high afterwards.
    task automatic send_pixel(lanes_t px, bit ls, bit typed, lanes_t golden);
        lanes_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= ls;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = box_filter_predict(px, ls);
        pending_pixels.push_back(typed ? golden : predicted);
    endtask

    task automatic pause_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Lets the block drain completely, then writes the window length.
    task automatic set_window_length(logic [LEN_REG_W-1:0] len);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        window_length_wr_en   <= 1'b1;
        window_length_wr_data <= len;
        @(posedge clk);
        window_length_wr_en <= 1'b0;
        cfg_len = len;
    endtask

    // Output side: checks every transaction and stalls in random bursts.
    initial
    begin
        int stall_left;
        int rate;
        int cyc;
        bit hold_done;
        stall_left = 0;
        rate       = 0;
        cyc        = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_filtered(m_tdata);
            cyc++;
            if (cyc % 64 == 0)
                rate = $urandom_range(0, 2);
            // One long hold-off so that the block fills up and stalls its input.
            if (long_hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && rate != 0 && $urandom_range(0, (rate == 1) ? 7 : 2) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Input side: directed table, then random phases of lines.
    initial
    begin
        int              random_sent;
        int              phase_len;
        int              line_left;
        int unsigned     eff;
        bit              quiet;
        bit              ls;
        lanes_t          px;
        logic [LEN_REG_W-1:0] len;

        rst_n                 = 1'b0;
        s_tvalid              = 1'b0;
        s_tdata               = '0;
        s_tuser               = 1'b0;
        window_length_wr_en   = 1'b0;
        window_length_wr_data = '0;
        mismatch_count        = 0;
        calm                  = 1'b0;
        long_hold_req         = 1'b0;

        // Predictor state after reset.
        cfg_len    = 1;
        active_len = 1;
        wr_slot    = 0;
        fill_cnt   = 0;
        line_edge  = '0;
        for (int c = 0; c < NUM_CHAN; c++)
            lane_sum[c] = 0;

        // Before any line start the window is black at length one: the pixel passes.
        add_step(LEN_KEEP, 0, 10, 20, 30, 0, GOLDEN, 10, 20, 30);
        add_step(LEN_KEEP, 0, 255, 255, 255, 1, GOLDEN, 255, 255, 255);
        add_step(LEN_KEEP, 0, 0, 0, 0, 0, GOLDEN, 0, 0, 0);
        // A length of zero acts as one.
        add_step(LEN_WRITE, 0, 255, 0, 128, 1, GOLDEN, 255, 0, 128);
        add_step(LEN_KEEP, 0, 1, 2, 3, 0, GOLDEN, 1, 2, 3);
        // Full window.
        add_step(LEN_WRITE, 64, 255, 255, 255, 1, GOLDEN, 255, 255, 255);
        add_step(LEN_KEEP, 0, 0, 0, 0, 0, PREDICTED, 0, 0, 0);
        add_step(LEN_KEEP, 0, 0, 255, 17, 0, PREDICTED, 0, 0, 0);
        add_step(LEN_KEEP, 0, 128, 64, 32, 0, PREDICTED, 0, 0, 0);
        // Lengths above the store size are limited to it.
        add_step(LEN_WRITE, 127, 0, 0, 0, 1, GOLDEN, 0, 0, 0);
        add_step(LEN_KEEP, 0, 255, 255, 255, 0, PREDICTED, 0, 0, 0);
        add_step(LEN_KEEP, 0, 255, 255, 255, 0, PREDICTED, 0, 0, 0);
        add_step(LEN_WRITE, 65, 128, 128, 128, 1, GOLDEN, 128, 128, 128);
        add_step(LEN_KEEP, 0, 255, 0, 255, 0, PREDICTED, 0, 0, 0);
        // A length written mid-line waits for the next line start.
        add_step(LEN_WRITE, 2, 7, 8, 9, 0, PREDICTED, 0, 0, 0);
        add_step(LEN_KEEP, 0, 200, 100, 50, 1, GOLDEN, 200, 100, 50);
        add_step(LEN_KEEP, 0, 0, 0, 0, 0, GOLDEN, 100, 50, 25);
        add_step(LEN_KEEP, 0, 0, 0, 0, 0, GOLDEN, 0, 0, 0);
        add_step(LEN_WRITE, 3, 9, 9, 9, 1, GOLDEN, 9, 9, 9);
        add_step(LEN_KEEP, 0, 0, 3, 6, 0, PREDICTED, 0, 0, 0);
        add_step(LEN_KEEP, 0, 255, 255, 255, 0, PREDICTED, 0, 0, 0);
        // Back-to-back line starts.
        add_step(LEN_KEEP, 0, 1, 1, 1, 1, GOLDEN, 1, 1, 1);
        add_step(LEN_KEEP, 0, 2, 2, 2, 1, GOLDEN, 2, 2, 2);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].wr)
                set_window_length(directed_steps[i].len);
            send_pixel(directed_steps[i].px, directed_steps[i].ls,
                       directed_steps[i].typed, directed_steps[i].golden);
            if ($urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 10));
        end

        // Random part: each phase sets a length and streams lines of random pixels.
        random_sent = 0;
        line_left   = 0;
        while (random_sent < 850)
        begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = 1;
                2:       len = LEN_REG_W'(MAX_WINDOW);
                3:       len = LEN_REG_W'($urandom_range(MAX_WINDOW + 1, 127));
                4:       len = 127;
                default: len = LEN_REG_W'($urandom_range(2, MAX_WINDOW));
            endcase
            set_window_length(len);
            eff       = effective_length(len);
            quiet     = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 100);
            // Most phases open with a line start; some continue the line in progress.
            if ($urandom_range(0, 4) != 0)
                line_left = 0;
            repeat (phase_len)
            begin
                if (line_left == 0)
                begin
                    ls        = 1'b1;
                    line_left = $urandom_range(1, 3 * eff + 2);
                end
                else
                begin
                    ls = ($urandom_range(0, 39) == 0);
                end
                line_left--;
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    case ($urandom_range(0, 9))
                        0:       px[c] = 8'd0;
                        1:       px[c] = 8'd255;
                        default: px[c] = 8'($urandom_range(0, 255));
                    endcase
                end
                send_pixel(px, ls, PREDICTED, '0);
                random_sent++;
                calm = (random_sent >= 750);
                if (random_sent == 400)
                    long_hold_req = 1'b1;
                if (!calm && !quiet && $urandom_range(0, 4) == 0)
                    pause_sender($urandom_range(1, 10));
            end
        end

        // Drain and allow a few extra cycles for stray output transactions.
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
